// File: hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/swmmm_pkg.sv
`default_nettype none
package swmmm_pkg;

    localparam int WINDOW_DEF      = 12;
    localparam int SAMPLE_BITS_DEF = 16;

    // Field widths on the ports
    localparam int FIELD_W  = 16;
    localparam int FILLED_W = 4;

    localparam int S_TDATA_W = FIELD_W;
    localparam int M_FIELDS_W = 3 * FIELD_W + FILLED_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELDS_W;

endpackage
`default_nettype wire

// File: hdl/sliding_window_min_max_mean.sv
`default_nettype none
// Channel   Dir  tdata fields (low bit up)                    Beat
// s_axis    in   sample[15:0]                                 one sample
// m_axis    out  highest[15:0] lowest[31:16] mean[47:32]       one result
//                filled[51:48], zero pad[55:52]
//
// One sample at a time: a new sample is taken only once the last result is built.
// The sum is SUM_W = SAMPLE_BITS + clog2(WINDOW + 1) bits wide.
// The walk reads the ring memory one entry per cycle on its single read port,
// then a restoring divider yields one quotient bit per cycle.
// Reset (synchronous, active low) empties the window; ring contents are not cleared.
// A result waiting in the output register does not block the next sample.
module sliding_window_min_max_mean
    import swmmm_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // sample
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata    // highest, lowest, mean, filled, pad
);

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int PAD_W  = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;
    localparam int CPAD_W = (CNT_W > FILLED_W) ? CNT_W : FILLED_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_slot, n_slot;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_rd_vld, n_rd_vld;
    logic [SAMPLE_BITS-1:0] r_hi, n_hi;
    logic [SAMPLE_BITS-1:0] r_lo, n_lo;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [SUM_W-1:0]       r_quo, n_quo;
    logic [CNT_W-1:0]       r_rem, n_rem;
    logic [STEP_W-1:0]      r_step, n_step;
    logic                   r_out_vld, n_out_vld;
    logic [M_TDATA_W-1:0]   r_out_data, n_out_data;

    logic                   s_acc;
    logic                   rd_en;
    logic [PAD_W-1:0]       in_pad;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [CNT_W:0]         trial;
    logic                   ge;
    logic [PAD_W-1:0]       hi_pad, lo_pad, mean_pad;
    logic [CPAD_W-1:0]      fill_pad;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign in_pad     = PAD_W'(i_s_tdata);
    assign w_sample   = in_pad[SAMPLE_BITS-1:0];
    assign rd_en      = (r_state == S_SCAN) && (r_idx != r_fill);

    // Restoring divide step: bring down the next dividend bit
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign ge    = (trial >= {1'b0, r_fill});

    assign hi_pad   = PAD_W'(r_hi);
    assign lo_pad   = PAD_W'(r_lo);
    assign mean_pad = PAD_W'(r_quo[SAMPLE_BITS-1:0]);
    assign fill_pad = CPAD_W'(r_fill);

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mem[r_slot] <= w_sample;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_hi       = r_hi;
        n_lo       = r_lo;
        n_sum      = r_sum;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_step     = r_step;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_data = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_slot = (r_slot == IDX_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                    if (r_fill != CNT_W'(WINDOW)) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_idx   = '0;
                    n_hi    = '0;
                    n_lo    = '1;
                    n_sum   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    if (r_rd_data > r_hi) begin
                        n_hi = r_rd_data;
                    end
                    if (r_rd_data < r_lo) begin
                        n_lo = r_rd_data;
                    end
                    n_sum = r_sum + SUM_W'(r_rd_data);
                end else if (!rd_en) begin
                    // Walk drained: the sum is final
                    n_quo   = r_sum;
                    n_rem   = '0;
                    n_step  = STEP_W'(SUM_W);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = ge ? CNT_W'(trial - {1'b0, r_fill}) : trial[CNT_W-1:0];
                n_quo  = {r_quo[SUM_W-2:0], ge};
                n_step = r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Hold until the output register is free
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {{M_PAD_W{1'b0}}, fill_pad[FILLED_W-1:0],
                                  mean_pad[FIELD_W-1:0], lo_pad[FIELD_W-1:0],
                                  hi_pad[FIELD_W-1:0]};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slot    <= '0;
            r_fill    <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_slot    <= n_slot;
            r_fill    <= n_fill;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_sum      <= n_sum;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule
`default_nettype wire

// File: hdl/swmmm_chk.sv
`default_nettype none
`include "assert_macros.svh"
module swmmm_chk
    import swmmm_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_tvalid,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata
);

    logic [FIELD_W-1:0]  hi_f, lo_f, mean_f;
    logic [FILLED_W-1:0] fill_f;

    assign hi_f   = o_m_tdata[FIELD_W-1:0];
    assign lo_f   = o_m_tdata[2*FIELD_W-1:FIELD_W];
    assign mean_f = o_m_tdata[3*FIELD_W-1:2*FIELD_W];
    assign fill_f = o_m_tdata[3*FIELD_W+FILLED_W-1:3*FIELD_W];

    `ASSERT_ALWAYS(a_no_out_after_rst, !i_rst_n |=> !o_m_tvalid, "result valid after reset")
    `ASSERT_CLK(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")
    `ASSERT_CLK(a_busy_after_beat, i_s_tvalid && o_s_tready |=> !o_s_tready, "sample taken while busy")
    `ASSERT_CLK(a_order, o_m_tvalid |-> lo_f <= mean_f && mean_f <= hi_f, "mean outside min and max")
    `ASSERT_CLK(a_filled, o_m_tvalid |-> fill_f != '0, "result with empty window")

endmodule

bind sliding_window_min_max_mean swmmm_chk u_swmmm_chk (.*);
`default_nettype wire

// File: verif/tb_sliding_window_min_max_mean.sv
`timescale 1ns / 1ps

module tb_sliding_window_min_max_mean;
    import swmmm_pkg::*;

    localparam int WINDOW         = WINDOW_DEF;
    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS   = 1376;
    localparam int MAX_GAP        = 13;
    localparam int HOLD_CYCLES    = 600;
    localparam int HOLD_START_A   = 2000;
    localparam int HOLD_START_B   = 25000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int CYCLE_LIMIT    = 600000;

    typedef struct packed {
        logic [FIELD_W-1:0]  highest;
        logic [FIELD_W-1:0]  lowest;
        logic [FIELD_W-1:0]  mean;
        logic [FILLED_W-1:0] filled;
    } t_window_stats;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // sample
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // highest, lowest, mean, filled, pad

    logic [FIELD_W-1:0]   sample_queue[$];
    t_window_stats        expected_stats[$];

    // Predictor state: ring of held samples, next slot, held count
    logic [SAMPLE_BITS_DEF-1:0] ring[WINDOW];
    int unsigned          ring_slot = 0;
    int unsigned          ring_held = 0;

    int unsigned          tx_wait = 0;
    int unsigned          rx_wait = 0;
    int unsigned          hold_left = 0;
    logic                 hold_rx = 1'b0;
    int unsigned          samples_sent = 0;
    int unsigned          results_checked = 0;
    int unsigned          stall_cycles = 0;
    int unsigned          mismatches = 0;
    int unsigned          cycle_count = 0;

    sliding_window_min_max_mean u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int unsigned pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Take the oldest pending sample off the queue
    function automatic logic [FIELD_W-1:0] take_sample();
        logic [FIELD_W-1:0] head;
        head = sample_queue[0];
        sample_queue.delete(0);
        return head;
    endfunction

    // Insert one sample into the ring and work out the statistics of what is held
    function automatic t_window_stats advance_window(input logic [FIELD_W-1:0] sample);
        t_window_stats     stats;
        longint unsigned   total;
        logic [SAMPLE_BITS_DEF-1:0] peak;
        logic [SAMPLE_BITS_DEF-1:0] trough;
        ring[ring_slot] = sample[SAMPLE_BITS_DEF-1:0];
        ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
        if (ring_held < WINDOW)
            ring_held++;
        peak   = ring[0];
        trough = ring[0];
        total  = 0;
        for (int unsigned i = 0; i < ring_held; i++) begin
            if (ring[i] > peak)
                peak = ring[i];
            if (ring[i] < trough)
                trough = ring[i];
            total += ring[i];
        end
        stats.highest = FIELD_W'(peak);
        stats.lowest  = FIELD_W'(trough);
        stats.mean    = FIELD_W'(total / ring_held);
        stats.filled  = FILLED_W'(ring_held);
        return stats;
    endfunction

    // Sender: one beat per queued sample, random gap (none in calm stretches) before each
    always @(posedge clk) begin
        int unsigned gap;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            tx_wait  <= pick_gap(1'b0);
        end else if (s_tvalid && s_tready) begin
            samples_sent = samples_sent + 1;
            gap = pick_gap(((samples_sent / 90) % 3) == 2);
            if (gap == 0 && sample_queue.size() != 0) begin
                s_tdata <= take_sample();
            end else begin
                s_tvalid <= 1'b0;
                tx_wait  <= gap;
            end
        end else if (!s_tvalid) begin
            if (tx_wait != 0) begin
                tx_wait <= tx_wait - 1;
            end else if (sample_queue.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= take_sample();
            end
        end
    end

    // Long receiver hold: keep the block backed up into its input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_rx   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                hold_rx <= 1'b0;
        end else if (cycle_count == HOLD_START_A || cycle_count == HOLD_START_B) begin
            hold_rx   <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Receiver: predict on every accepted sample, then check the result beat
    always @(posedge clk) begin
        t_window_stats want;
        int unsigned   gap;
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_wait  <= pick_gap(1'b0);
        end else begin
            if (s_tvalid && s_tready)
                expected_stats = {expected_stats, advance_window(s_tdata)};
            if (s_tvalid && !s_tready)
                stall_cycles = stall_cycles + 1;

            if (m_tvalid && m_tready) begin
                if (expected_stats.size() == 0) begin
                    $error("result beat with no sample pending: tdata %h", m_tdata);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_stats[0];
                    expected_stats.delete(0);
                    if (m_tdata[15:0] !== want.highest) begin
                        $error("highest: expected %0d, actual %0d", want.highest, m_tdata[15:0]);
                        mismatches = mismatches + 1;
                    end
                    if (m_tdata[31:16] !== want.lowest) begin
                        $error("lowest: expected %0d, actual %0d", want.lowest, m_tdata[31:16]);
                        mismatches = mismatches + 1;
                    end
                    if (m_tdata[47:32] !== want.mean) begin
                        $error("mean: expected %0d, actual %0d", want.mean, m_tdata[47:32]);
                        mismatches = mismatches + 1;
                    end
                    if (m_tdata[51:48] !== want.filled) begin
                        $error("filled: expected %0d, actual %0d", want.filled, m_tdata[51:48]);
                        mismatches = mismatches + 1;
                    end
                    if (m_tdata[M_TDATA_W-1:M_FIELDS_W] !== '0) begin
                        $error("pad: expected 0, actual %0d", m_tdata[M_TDATA_W-1:M_FIELDS_W]);
                        mismatches = mismatches + 1;
                    end
                end
                results_checked = results_checked + 1;
                if (hold_rx) begin
                    m_tready <= 1'b0;
                end else begin
                    gap = pick_gap(((results_checked / 75) % 4) == 1);
                    if (gap != 0) begin
                        m_tready <= 1'b0;
                        rx_wait  <= gap;
                    end
                end
            end else if (!m_tready) begin
                if (!hold_rx) begin
                    if (rx_wait != 0)
                        rx_wait <= rx_wait - 1;
                    else
                        m_tready <= 1'b1;
                end
            end else if (hold_rx) begin
                m_tready <= 1'b0;
            end
        end
    end

    initial begin
        logic [FIELD_W-1:0] prev_sample;
        logic [FIELD_W-1:0] value;
        int unsigned        bit_pos;

        // Extremes and alternating patterns fill the window, then all-max wraps it
        sample_queue = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF,
                         16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 16'h0000, 16'h1234};
        repeat (DIRECTED_ITEMS - 12) sample_queue = {sample_queue, 16'hFFFF};

        prev_sample = 16'hFFFF;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 9))
                5:       value = FIELD_W'($urandom_range(0, 15));
                6:       value = FIELD_W'($urandom_range(65520, 65535));
                7:       value = prev_sample;
                8:       value = FIELD_W'($urandom_range(16'h7FC0, 16'h803F));
                9: begin
                    bit_pos = $urandom_range(0, FIELD_W - 1);
                    value   = FIELD_W'(1) << bit_pos;
                    if ($urandom_range(0, 1))
                        value = ~value;
                end
                default: value = FIELD_W'($urandom());
            endcase
            sample_queue = {sample_queue, value};
            prev_sample = value;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (sample_queue.size() != 0 || s_tvalid || expected_stats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results against %0d samples through a %0d-deep window;",
                 results_checked, samples_sent, WINDOW);
        $display("input held back by the block on %0d cycles.", stall_cycles);
        if (mismatches == 0 && expected_stats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

endmodule
